// ===== sv/pspm_pkg.sv =====
package pspm_pkg;

  // Default sizes of the player
  localparam int NUM_VOICES_DEF  = 8;
  localparam int NUM_SLOTS_DEF   = 16;
  localparam int SLOT_FRAMES_DEF = 4096;
  localparam int BASE_NOTE_DEF   = 36;

  // Fixed field widths
  localparam int SLOT_FW    = 4;
  localparam int WADDR_FW   = 12;
  localparam int SAMPLE_FW  = 16;
  localparam int COUNT_FW   = 13;
  localparam int CHAN_FW    = 4;
  localparam int NOTE_FW    = 7;
  localparam int VEL_FW     = 7;
  localparam int MASK_FW    = 8;

  // Full-scale velocity and the reciprocal used to divide by it
  localparam int VEL_FULL    = 127;
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + VEL_FULL - 1) / VEL_FULL;
  localparam int RECIP_W     = 23;

  // Mixer limits
  localparam logic signed [SAMPLE_FW:0] MIX_MAX = 17'sd32767;
  localparam logic signed [SAMPLE_FW:0] MIX_MIN = -17'sd32768;

  // Configuration register
  localparam logic [CHAN_FW-1:0] CHANNEL_RESET      = 4'd2;
  localparam logic               REG_LISTEN_CHANNEL = 1'b0;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_LENGTH = 2'd1,
    FUNC_NOTE   = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t                        func;
    logic [SLOT_FW-1:0]           slot;
    logic [WADDR_FW-1:0]          word_address;
    logic signed [SAMPLE_FW-1:0]  sample_word;
    logic [COUNT_FW-1:0]          frame_count;
    logic [CHAN_FW-1:0]           channel;
    logic [NOTE_FW-1:0]           note;
    logic [VEL_FW-1:0]            velocity;
    logic                         is_note_on;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_FW-1:0]  mix_sample;
    logic [MASK_FW-1:0]           active_mask;
  } frame_t;

endpackage

// ===== sv/pspm_scale.sv =====
module pspm_scale import pspm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  logic signed [SAMPLE_FW-1:0] sample,
  input  logic [VEL_FW-1:0]           velocity,
  output logic                        busy,
  output logic                        scaled_valid,
  output logic signed [SAMPLE_FW-1:0] scaled
);

  localparam int PROD_W  = SAMPLE_FW + VEL_FW + 1;
  localparam int MAG_W   = PROD_W - 2;
  localparam int RPROD_W = MAG_W + RECIP_W;

  logic                       prod_valid;
  logic signed [PROD_W-1:0]   prod;
  logic                       recip_valid;
  logic                       recip_neg;
  logic [RPROD_W-1:0]         recip_prod;
  logic [PROD_W-1:0]          mag;
  logic [SAMPLE_FW-1:0]       quot;

  // sample times velocity
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= valid;
    end
    prod <= PROD_W'(sample) * PROD_W'(signed'({1'b0, velocity}));
  end

  // magnitude times reciprocal of 127, truncates toward zero
  assign mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      recip_valid <= 1'b0;
    end else begin
      recip_valid <= prod_valid;
    end
    recip_neg  <= prod[PROD_W-1];
    recip_prod <= RPROD_W'(mag[MAG_W-1:0]) * RPROD_W'(RECIP_MUL);
  end

  assign quot         = recip_prod[RECIP_SHIFT +: SAMPLE_FW];
  assign scaled       = recip_neg ? SAMPLE_FW'(-quot) : SAMPLE_FW'(quot);
  assign scaled_valid = recip_valid;
  assign busy         = prod_valid | recip_valid;

endmodule

// ===== sv/polyphonic_sample_player_mixer.sv =====
// Polyphonic drum sample player with a mono saturating mixer.
// Request channel (item, item_valid, item_stall): load a sample word, set a
// slot length, send a note event, or tick one frame. Load, length and note
// requests complete in the cycle they are accepted and produce no frame.
// A tick produces one frame on the frame channel (frame, frame_valid,
// frame_stall). A tick walks the voices one per cycle through the voice
// memory and the sample memory, then a two-stage velocity scaler, into the
// mixer and the frame register. No request is taken while a tick runs; the
// next is taken once the frame is in the frame register. The voice memory
// port and the sample memory read port limit the walk to one voice per cycle.
// The frame register holds the result while frame_stall is high; new
// load, length and note requests are still taken, and a following tick
// waits at its end until the frame register is free.
// Reset clears all voices, marks all slots unloaded and sets the listened
// channel to 2. Sample memory contents are not cleared.
// The APB port holds the listened MIDI channel at address 0.
module polyphonic_sample_player_mixer import pspm_pkg::*; #(
  parameter int NUM_VOICES  = NUM_VOICES_DEF,
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int SLOT_FRAMES = SLOT_FRAMES_DEF,
  parameter int BASE_NOTE   = BASE_NOTE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_stall,
  output frame_t      frame,
  output logic        frame_valid,
  input  logic        frame_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W   = $clog2(NUM_VOICES + 1);
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LEN_MAX = (SLOT_FRAMES < 8191) ? SLOT_FRAMES : 8191;
  localparam int LEN_W   = $clog2(LEN_MAX + 1);
  localparam int DEPTH   = NUM_SLOTS * SLOT_FRAMES;
  localparam int ADDR_W  = $clog2(DEPTH);

  typedef struct packed {
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] slot;
    logic [VEL_FW-1:0] vel;
  } voice_t;

  state_t state, state_next;

  logic [CHAN_FW-1:0]          listen_channel;
  logic [LEN_W-1:0]            slot_length [NUM_SLOTS];
  logic [NUM_VOICES-1:0]       voice_active;
  voice_t                      voice_mem [NUM_VOICES];
  logic signed [SAMPLE_FW-1:0] sample_mem [DEPTH];

  logic                        item_accept;
  logic                        issue_en;
  logic                        mix_done;
  logic                        frame_load;
  logic [CNT_W-1:0]            issue_cnt;
  logic [VOICE_W-1:0]          issue_idx;

  logic                        s1_valid;
  logic [VOICE_W-1:0]          s1_idx;
  voice_t                      vrd;
  logic                        s1_go;
  logic                        s1_end;
  logic                        s1_play;
  logic                        s2_valid;
  logic [VEL_FW-1:0]           s2_vel;
  logic signed [SAMPLE_FW-1:0] smp;

  logic                        scale_busy;
  logic                        scale_valid;
  logic signed [SAMPLE_FW-1:0] scaled;
  logic signed [SAMPLE_FW-1:0] mix;
  logic signed [SAMPLE_FW:0]   mix_sum;
  logic [MASK_FW-1:0]          mask;

  logic                        load_hit;
  logic                        len_hit;
  logic [COUNT_FW-1:0]         len_sat;
  logic [NOTE_FW:0]            note_off;
  logic [SLOT_W-1:0]           note_slot;
  logic                        note_hit;
  logic [VOICE_W-1:0]          pick;
  logic                        cfg_we;

  assign item_accept = item_valid && !item_stall;
  assign issue_idx   = issue_cnt[VOICE_W-1:0];

  // APB register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_LISTEN_CHANNEL);
  assign prdata = (paddr[2] == REG_LISTEN_CHANNEL) ? {28'd0, listen_channel} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= CHANNEL_RESET;
    end else if (cfg_we) begin
      listen_channel <= pwdata[CHAN_FW-1:0];
    end
  end

  // Request decode
  assign load_hit = item_accept && (item.func == FUNC_LOAD)
                    && (32'(item.slot) < NUM_SLOTS) && (32'(item.word_address) < SLOT_FRAMES);
  assign len_hit  = item_accept && (item.func == FUNC_LENGTH) && (32'(item.slot) < NUM_SLOTS);
  assign len_sat  = (32'(item.frame_count) > SLOT_FRAMES) ? COUNT_FW'(SLOT_FRAMES)
                                                          : item.frame_count;
  assign note_off  = {1'b0, item.note} - (NOTE_FW+1)'(BASE_NOTE);
  assign note_slot = note_off[SLOT_W-1:0];
  assign note_hit  = item_accept && (item.func == FUNC_NOTE)
                     && (item.channel == listen_channel) && item.is_note_on
                     && (item.velocity != '0)
                     && (32'(item.note) >= BASE_NOTE)
                     && (32'(item.note) < BASE_NOTE + NUM_SLOTS)
                     && (slot_length[note_slot] != '0);

  // First idle voice, voice 0 when all are busy
  always_comb begin
    pick = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (!voice_active[v]) begin
        pick = VOICE_W'(v);
      end
    end
  end

  // Slot lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_length[s] <= '0;
      end
    end else if (len_hit) begin
      slot_length[item.slot[SLOT_W-1:0]] <= LEN_W'(len_sat);
    end
  end

  // Sample memory: written by loads, read one voice per cycle during a tick
  always_ff @(posedge clk) begin
    if (load_hit) begin
      sample_mem[ADDR_W'(item.slot[SLOT_W-1:0]) * ADDR_W'(SLOT_FRAMES)
                 + ADDR_W'(item.word_address)] <= item.sample_word;
    end
    if (s1_play) begin
      smp <= sample_mem[ADDR_W'(vrd.slot) * ADDR_W'(SLOT_FRAMES) + ADDR_W'(vrd.pos)];
    end
  end

  // Voice memory: note start or position write-back, read at the issue index
  always_ff @(posedge clk) begin
    if (note_hit) begin
      voice_mem[pick] <= '{pos: '0, len: slot_length[note_slot],
                           slot: note_slot, vel: item.velocity};
    end else if (s1_play) begin
      voice_mem[s1_idx] <= '{pos: vrd.pos + LEN_W'(1), len: vrd.len,
                             slot: vrd.slot, vel: vrd.vel};
    end
    if (issue_en) begin
      vrd <= voice_mem[issue_idx];
    end
  end

  // Voice check stage
  assign s1_go   = s1_valid && voice_active[s1_idx];
  assign s1_end  = s1_go && (vrd.pos >= vrd.len);
  assign s1_play = s1_go && !s1_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
    end else if (note_hit) begin
      voice_active[pick] <= 1'b1;
    end else if (s1_end) begin
      voice_active[s1_idx] <= 1'b0;
    end
  end

  // Pipeline valids and issue counter
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      issue_cnt <= '0;
    end else begin
      s1_valid <= issue_en;
      s2_valid <= s1_play;
      if (item_accept && (item.func == FUNC_TICK)) begin
        issue_cnt <= '0;
      end else if (issue_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
    end
    s1_idx <= issue_idx;
    s2_vel <= vrd.vel;
  end

  pspm_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .valid        (s2_valid),
    .sample       (smp),
    .velocity     (s2_vel),
    .busy         (scale_busy),
    .scaled_valid (scale_valid),
    .scaled       (scaled)
  );

  // Saturating accumulate, voices in order
  assign mix_sum = (SAMPLE_FW+1)'(mix) + (SAMPLE_FW+1)'(scaled);

  always_ff @(posedge clk) begin
    if (item_accept && (item.func == FUNC_TICK)) begin
      mix <= '0;
    end else if (scale_valid) begin
      priority if (mix_sum > MIX_MAX) begin
        mix <= MIX_MAX[SAMPLE_FW-1:0];
      end else if (mix_sum < MIX_MIN) begin
        mix <= MIX_MIN[SAMPLE_FW-1:0];
      end else begin
        mix <= mix_sum[SAMPLE_FW-1:0];
      end
    end
  end

  // Active mask, first eight voices
  for (genvar i = 0; i < MASK_FW; i++) begin : g_mask
    if (i < NUM_VOICES) begin : g_on
      assign mask[i] = voice_active[i];
    end else begin : g_off
      assign mask[i] = 1'b0;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_accept && (item.func == FUNC_TICK)) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        if (mix_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (frame_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    item_stall = 1'b1;
    issue_en   = 1'b0;
    mix_done   = 1'b0;
    frame_load = 1'b0;
    unique case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_MIX: begin
        issue_en = (issue_cnt < CNT_W'(NUM_VOICES));
        mix_done = (issue_cnt == CNT_W'(NUM_VOICES)) && !s1_valid && !s2_valid
                   && !scale_busy;
      end
      ST_DONE: frame_load = !frame_valid || !frame_stall;
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_load) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
    if (frame_load) begin
      frame <= '{mix_sample: mix, active_mask: mask};
    end
  end

`ifndef ASSERT_OFF
  // Pipeline is empty whenever requests are taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!s1_valid && !s2_valid && !scale_busy))
    else $error("tick pipeline not drained in idle");

  // A tick only retires voices, never starts them
  a_mix_only_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MIX) && ($past(state) == ST_MIX))
      |-> ((voice_active & ~$past(voice_active)) == '0))
    else $error("voice started during a tick");

  // A frame appears only at the end of a tick
  a_frame_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_valid) |-> ($past(state) == ST_DONE))
    else $error("frame without a finished tick");

  // Issue counter stays within the voice count
  a_issue_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX) |-> (issue_cnt <= CNT_W'(NUM_VOICES)))
    else $error("issue counter overran");
`endif

endmodule

// ===== tb/tb_polyphonic_sample_player_mixer.sv =====
`timescale 1ns / 100ps

module tb_polyphonic_sample_player_mixer;
  import pspm_pkg::*;

  localparam int STORE_WORDS = NUM_SLOTS_DEF * SLOT_FRAMES_DEF;
  localparam logic [2:0] CHANNEL_ADDR = 3'(4 * REG_LISTEN_CHANNEL);
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 30;
  localparam int FILL_CAP = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  item_t       item = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  frame_t      frame;
  logic        frame_valid;
  logic        frame_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  polyphonic_sample_player_mixer uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // player state as the block should hold it
  logic signed [SAMPLE_FW-1:0] pcm_mem [STORE_WORDS];
  bit                          pcm_written [STORE_WORDS];
  logic [COUNT_FW-1:0]         slot_len [NUM_SLOTS_DEF] = '{default: '0};
  int                          slot_fill [NUM_SLOTS_DEF];  // written prefix per slot
  bit                          vc_on [NUM_VOICES_DEF];
  int                          vc_pos [NUM_VOICES_DEF];
  int                          vc_slot [NUM_VOICES_DEF];
  int                          vc_vel [NUM_VOICES_DEF];
  int                          vc_len [NUM_VOICES_DEF];
  logic [CHAN_FW-1:0]          listen_ch = CHANNEL_RESET;

  frame_t mix_q [$];
  int     miss_count = 0;
  int     took_count;
  int     burst_left = 0;

  function automatic void log_miss(input string what, input int want, input int got);
    miss_count++;
    if (miss_count <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
  endfunction

  // slot that a note event starts, or -1 when the block ignores it
  function automatic int note_target(input item_t it);
    int s;
    s = int'(it.note) - BASE_NOTE_DEF;
    if (it.channel != listen_ch || !it.is_note_on || it.velocity == '0) return -1;
    if (s < 0 || s >= NUM_SLOTS_DEF) return -1;
    if (slot_len[s] == '0) return -1;
    return s;
  endfunction

  // apply one accepted request; a tick queues the frame it must produce
  function automatic void play_request(input item_t it);
    int s, pick, idx, mix, add;
    logic [MASK_FW-1:0] mask;
    frame_t fr;
    case (it.func)
      FUNC_LOAD: begin
        s = int'(it.slot);
        idx = s * SLOT_FRAMES_DEF + int'(it.word_address);
        pcm_mem[idx] = it.sample_word;
        pcm_written[idx] = 1'b1;
        while (slot_fill[s] < SLOT_FRAMES_DEF &&
               pcm_written[s * SLOT_FRAMES_DEF + slot_fill[s]])
          slot_fill[s]++;
      end
      FUNC_LENGTH: begin
        slot_len[it.slot] = (it.frame_count > SLOT_FRAMES_DEF) ?
                            COUNT_FW'(SLOT_FRAMES_DEF) : it.frame_count;
      end
      FUNC_NOTE: begin
        s = note_target(it);
        if (s >= 0) begin
          // lowest idle voice, else steal voice 0
          pick = 0;
          for (int v = 0; v < NUM_VOICES_DEF; v++)
            if (!vc_on[v]) begin
              pick = v;
              break;
            end
          vc_on[pick] = 1'b1;
          vc_pos[pick] = 0;
          vc_slot[pick] = s;
          vc_vel[pick] = int'(it.velocity);
          vc_len[pick] = int'(slot_len[s]);
        end
      end
      FUNC_TICK: begin
        mix = 0;
        mask = '0;
        for (int v = 0; v < NUM_VOICES_DEF; v++) begin
          if (vc_on[v] && vc_pos[v] >= vc_len[v]) begin
            vc_on[v] = 1'b0;
          end else if (vc_on[v]) begin
            add = int'(pcm_mem[vc_slot[v] * SLOT_FRAMES_DEF + vc_pos[v]]) * vc_vel[v]
                  / VEL_FULL;
            vc_pos[v]++;
            mix += add;
            if (mix > MIX_MAX) mix = MIX_MAX;
            else if (mix < MIX_MIN) mix = MIX_MIN;
          end
          if (vc_on[v]) mask[v] = 1'b1;
        end
        fr.mix_sample = SAMPLE_FW'(mix);
        fr.active_mask = mask;
        mix_q.push_back(fr);
      end
      default: ;
    endcase
  endfunction

  // random bits everywhere, then the operation
  function automatic item_t noise_item(input func_t f);
    logic [95:0] raw;
    item_t it;
    raw = {$urandom, $urandom, $urandom};
    it = item_t'(raw[$bits(item_t)-1:0]);
    it.func = f;
    return it;
  endfunction

  // send one request; the sender runs in bursts with random gaps
  task automatic push_request(input item_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    play_request(it);
    took_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
                   $urandom_range(0, 15);
    end
  endtask

  // wait for every queued frame, then let the block go quiet
  task automatic settle;
    item_valid <= 1'b0;
    while (mix_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CHAN_FW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CHANNEL_ADDR;
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    listen_ch = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CHANNEL_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CHAN_FW-1:0] !== listen_ch)
      log_miss("listen_channel readback", int'(listen_ch), int'(prdata[CHAN_FW-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_word(input int s, input int a, input int w);
    item_t it;
    it = noise_item(FUNC_LOAD);
    it.slot = SLOT_FW'(s);
    it.word_address = WADDR_FW'(a);
    it.sample_word = SAMPLE_FW'(w);
    push_request(it);
  endtask

  task automatic set_length(input int s, input int n);
    item_t it;
    it = noise_item(FUNC_LENGTH);
    it.slot = SLOT_FW'(s);
    it.frame_count = COUNT_FW'(n);
    push_request(it);
  endtask

  task automatic note_req(input int ch, input int nt, input int vel, input bit on);
    item_t it;
    it = noise_item(FUNC_NOTE);
    it.channel = CHAN_FW'(ch);
    it.note = NOTE_FW'(nt);
    it.velocity = VEL_FW'(vel);
    it.is_note_on = on;
    push_request(it);
  endtask

  task automatic tick_frame;
    push_request(noise_item(FUNC_TICK));
  endtask

  // frame checker and receiver stall pattern
  int stall_mode = 0;
  int stall_span = 0;

  always @(posedge clk) begin : frame_rx
    frame_t want;
    if (!rst && frame_valid && !frame_stall) begin
      if (mix_q.size() == 0) begin
        miss_count++;
        if (miss_count <= 10)
          $display("MISMATCH unexpected frame: mix %0d mask %02h",
                   frame.mix_sample, frame.active_mask);
      end else begin
        want = mix_q.pop_front();
        if (frame.mix_sample !== want.mix_sample)
          log_miss("mix_sample", int'(want.mix_sample), int'(frame.mix_sample));
        if (frame.active_mask !== want.active_mask)
          log_miss("active_mask", int'(want.active_mask), int'(frame.active_mask));
      end
    end
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: frame_stall <= 1'b0;
      1: frame_stall <= ($urandom_range(0, 3) == 0);
      2: frame_stall <= ($urandom_range(0, 3) != 0);
      default: frame_stall <= ~frame_stall;
    endcase
  end

  // watchdog: too long without any transfer
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (frame_valid && !frame_stall) ||
        (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // reset value, then both channel extremes
  task automatic test_listen_register;
    reg_check;
    reg_write(4'd15);
    reg_check;
    reg_write(4'd0);
    reg_check;
    reg_write(CHANNEL_RESET);
  endtask

  // full-scale voices, saturation both ways, length change under a playing voice
  task automatic test_mix_saturation;
    load_word(0, 0, 32767);
    load_word(0, 1, -32768);
    load_word(0, 4095, 16'h5AA5);
    set_length(0, 2);
    load_word(15, 0, -32768);
    set_length(15, 1);
    note_req(CHANNEL_RESET, 36, 127, 1'b1);
    note_req(CHANNEL_RESET, 36, 127, 1'b1);
    note_req(CHANNEL_RESET, 51, 127, 1'b1);
    tick_frame;
    set_length(0, 8191);  // saturates; playing voices keep their length
    tick_frame;
    tick_frame;
  endtask

  // events that must not start a voice
  task automatic test_ignored_notes;
    note_req(3, 51, 127, 1'b1);
    note_req(CHANNEL_RESET, 51, 127, 1'b0);
    note_req(CHANNEL_RESET, 51, 0, 1'b1);
    note_req(CHANNEL_RESET, 35, 127, 1'b1);
    note_req(CHANNEL_RESET, 37, 127, 1'b1);
    set_length(0, 0);
    note_req(CHANNEL_RESET, 36, 1, 1'b1);
    tick_frame;
  endtask

  // nine note-ons: the ninth takes voice 0
  task automatic test_voice_steal;
    for (int v = 0; v < NUM_VOICES_DEF + 1; v++)
      note_req(CHANNEL_RESET, 51, 1 + v * 15, 1'b1);
    tick_frame;
    settle;
  endtask

  task automatic test_random_phase(input logic [CHAN_FW-1:0] ch, input int target);
    item_t it;
    int pick, s, top;
    reg_write(ch);
    reg_check;
    took_count = 0;
    while (took_count < target) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, NUM_SLOTS_DEF - 1);
      if (pick < 30) begin
        it = noise_item(FUNC_TICK);
      end else if (pick < 55) begin
        it = noise_item(FUNC_NOTE);
        if ($urandom_range(0, 9) != 0) it.channel = listen_ch;
        if ($urandom_range(0, 9) != 0) it.note = NOTE_FW'(BASE_NOTE_DEF + s);
        if ($urandom_range(0, 9) != 0) it.is_note_on = 1'b1;
        // a voice may only start on a slot whose frames are all loaded
        s = note_target(it);
        if (s >= 0 && int'(slot_len[s]) > slot_fill[s]) it.velocity = '0;
      end else if (pick < 85) begin
        it = noise_item(FUNC_LOAD);
        it.slot = SLOT_FW'(s);
        if ($urandom_range(0, 4) != 0 && slot_fill[s] < FILL_CAP)
          it.word_address = WADDR_FW'(slot_fill[s]);
        if ($urandom_range(0, 9) == 0)
          it.sample_word = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end else begin
        it = noise_item(FUNC_LENGTH);
        it.slot = SLOT_FW'(s);
        top = (slot_fill[s] < FILL_CAP) ? slot_fill[s] : FILL_CAP;
        if ($urandom_range(0, 3) != 0) it.frame_count = COUNT_FW'($urandom_range(0, top));
      end
      push_request(it);
    end
    settle;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_listen_register;
    test_mix_saturation;
    test_ignored_notes;
    test_voice_steal;
    test_random_phase(4'd0, 150);
    test_random_phase(4'd15, 150);
    test_random_phase(CHAN_FW'($urandom_range(1, 14)), 150);
    test_random_phase(CHANNEL_RESET, 150);
    if (miss_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== polyphonic_sample_player_mixer.f =====
sv/pspm_pkg.sv
sv/pspm_scale.sv
sv/polyphonic_sample_player_mixer.sv
tb/tb_polyphonic_sample_player_mixer.sv
